@@ rtl/core/pidaw_pkg.sv @@
// shared types, constants and control store for the pid controller with anti-windup
`default_nettype none

package pidaw_pkg;

  // datapath widths
  localparam int DW   = 32;  // q16.16 data word
  localparam int IW   = 48;  // integral accumulator
  localparam int MW   = 33;  // multiplier operand
  localparam int PW   = 66;  // multiplier product
  localparam int AW   = 82;  // wide pid accumulator
  localparam int YW   = 46;  // tolerance product
  localparam int STW  = 4;   // microcode step index

  // configuration register indexes
  localparam logic [2:0] CFG_GAIN_P    = 3'd0;
  localparam logic [2:0] CFG_GAIN_I    = 3'd1;
  localparam logic [2:0] CFG_GAIN_D    = 3'd2;
  localparam logic [2:0] CFG_WRAP_MODE = 3'd3;
  localparam logic [2:0] CFG_INPUT_MIN = 3'd4;
  localparam logic [2:0] CFG_INPUT_MAX = 3'd5;
  localparam logic [2:0] CFG_DRIVE_MIN = 3'd6;
  localparam logic [2:0] CFG_DRIVE_MAX = 3'd7;

  // drive limit reset values, -1.0 and +1.0
  localparam logic [DW-1:0] DRIVE_MIN_RST = 32'hFFFF_0000;
  localparam logic [DW-1:0] DRIVE_MAX_RST = 32'h0001_0000;

  // on-target tolerance and scale constants
  localparam logic signed [MW-1:0] TOL_Q16  = 33'sd3277;
  localparam logic signed [MW-1:0] KX_SPAN  = 33'sd6553600;  // 100 * 65536
  localparam logic signed [MW-1:0] KX_UNIT  = 33'sd65536;

  typedef struct packed {
    logic [DW-1:0] gain_p;
    logic [DW-1:0] gain_i;
    logic [DW-1:0] gain_d;
    logic          wrap_mode;
    logic [DW-1:0] input_min;
    logic [DW-1:0] input_max;
    logic [DW-1:0] drive_min;
    logic [DW-1:0] drive_max;
  } cfg_t;

  // multiplier operand a select
  typedef enum logic [2:0] {
    OPA_SPAN,
    OPA_CAND_LO,
    OPA_CAND_HI,
    OPA_ABS_E,
    OPA_E,
    OPA_INT_LO,
    OPA_INT_HI,
    OPA_EDIF
  } opa_t;

  // multiplier operand b select
  typedef enum logic [2:0] {
    OPB_TOL,
    OPB_GI,
    OPB_GP,
    OPB_GD,
    OPB_KX
  } opb_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADDSH,
    ACC_CLR
  } acc_op_t;

  typedef logic [STW-1:0] step_t;

  // one control word
  typedef struct packed {
    opa_t    opa;
    opb_t    opb;
    logic    mul_en;
    acc_op_t acc_op;
    logic    err_ld;
    logic    cand_ld;
    logic    y_ld;
    logic    chk;
    logic    fin;
    step_t   jmp;
  } ctl_t;

  // step addresses
  localparam step_t ST_ERR     = 4'd0;
  localparam step_t ST_CAND    = 4'd1;
  localparam step_t ST_TI_LO   = 4'd2;
  localparam step_t ST_TI_HI   = 4'd3;
  localparam step_t ST_TOL_X   = 4'd4;
  localparam step_t ST_CHK     = 4'd5;
  localparam step_t ST_OI_HI   = 4'd6;
  localparam step_t ST_OI_LO   = 4'd7;
  localparam step_t ST_GD      = 4'd8;
  localparam step_t ST_SUM     = 4'd9;
  localparam step_t ST_FIN     = 4'd10;

  localparam ctl_t CTL_NOP = '{OPA_SPAN, OPB_TOL, 1'b0, ACC_HOLD,
                               1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};

  // control store: one word per step
  function automatic ctl_t ucode_rom(input step_t s);
    ctl_t w;
    w = CTL_NOP;
    unique case (s)
      // wrap and saturate the error
      ST_ERR:   w = '{OPA_SPAN, OPB_TOL, 1'b0, ACC_HOLD,
                      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      // candidate integral, tolerance product
      ST_CAND:  w = '{OPA_SPAN, OPB_TOL, 1'b1, ACC_HOLD,
                      1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ST_ERR};
      // candidate times gain_i, low half
      ST_TI_LO: w = '{OPA_CAND_LO, OPB_GI, 1'b1, ACC_HOLD,
                      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ST_ERR};
      ST_TI_HI: w = '{OPA_CAND_HI, OPB_GI, 1'b1, ACC_LOAD,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      // scaled error magnitude for the on-target test
      ST_TOL_X: w = '{OPA_ABS_E, OPB_KX, 1'b1, ACC_ADDSH,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      // limit check: keep candidate product and skip, or restart with old integral
      ST_CHK:   w = '{OPA_E, OPB_GP, 1'b1, ACC_CLR,
                      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ST_GD};
      ST_OI_HI: w = '{OPA_INT_HI, OPB_GI, 1'b1, ACC_ADD,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      ST_OI_LO: w = '{OPA_INT_LO, OPB_GI, 1'b1, ACC_ADDSH,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      ST_GD:    w = '{OPA_EDIF, OPB_GD, 1'b1, ACC_ADD,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      ST_SUM:   w = '{OPA_EDIF, OPB_GD, 1'b0, ACC_ADD,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_ERR};
      ST_FIN:   w = '{OPA_EDIF, OPB_GD, 1'b0, ACC_HOLD,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_ERR};
      default:  w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pid_controller_wrap_antiwindup.sv @@
// top level: configuration registers, sequencer, datapath and output register
//
// Position PID controller with conditional integration and optional error wrap.
// Input channel (in_*): one beat carries start, measured and target positions in
// signed Q16.16 and a flag that zeroes the integral before the step. A beat is
// taken when in_valid is high and in_stall is low; in_stall is high while an item
// is being worked on.
// Result channel (out_*): one beat per input beat with the clamped drive, the
// saturated raw error and the on-target flag, held in an output register.
// Each item runs through a microcode program on one shared 33x33 multiplier:
// 9 steps when the new integral is within limits, 11 when it is held back.
// The result is written to the output register at the last step, and a new beat
// is taken only once that step has completed.
// Configuration (cfg_*): a write lands when cfg_we is high; write only while idle.
// Reset (rst_n low, synchronous) clears the integral and the last error and loads
// the register defaults (gains zero, drive limits -1.0 and +1.0).
// When out_stall holds a result, the next item runs up to its last step and
// waits there until the output register frees.
`default_nettype none

module pid_controller_wrap_antiwindup
  import pidaw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [DW-1:0] in_start_pos,
  input  wire logic signed [DW-1:0] in_measured_pos,
  input  wire logic signed [DW-1:0] in_target_pos,
  input  wire logic                 in_clear_integral,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [DW-1:0]      out_drive,
  output logic signed [DW-1:0]      out_raw_error,
  output logic                      out_on_target,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [DW-1:0]        cfg_data
);

  cfg_t          cfg_r;
  ctl_t          ctl;
  logic          busy;
  logic          in_load;
  logic          out_free;
  logic          lim_in;
  logic [DW-1:0] drive_w;
  logic [DW-1:0] raw_w;
  logic          on_w;

  logic          out_valid_r;
  logic [DW-1:0] out_drive_r;
  logic [DW-1:0] out_raw_r;
  logic          out_on_r;

  assign in_stall = busy;
  assign in_load  = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p    <= '0;
      cfg_r.gain_i    <= '0;
      cfg_r.gain_d    <= '0;
      cfg_r.wrap_mode <= 1'b0;
      cfg_r.input_min <= '0;
      cfg_r.input_max <= '0;
      cfg_r.drive_min <= DRIVE_MIN_RST;
      cfg_r.drive_max <= DRIVE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:    cfg_r.gain_p    <= cfg_data;
        CFG_GAIN_I:    cfg_r.gain_i    <= cfg_data;
        CFG_GAIN_D:    cfg_r.gain_d    <= cfg_data;
        CFG_WRAP_MODE: cfg_r.wrap_mode <= cfg_data[0];
        CFG_INPUT_MIN: cfg_r.input_min <= cfg_data;
        CFG_INPUT_MAX: cfg_r.input_max <= cfg_data;
        CFG_DRIVE_MIN: cfg_r.drive_min <= cfg_data;
        CFG_DRIVE_MAX: cfg_r.drive_max <= cfg_data;
      endcase
    end
  end

  pidaw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_load),
    .out_free (out_free),
    .lim_in   (lim_in),
    .busy     (busy),
    .ctl      (ctl)
  );

  pidaw_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_load           (in_load),
    .in_start_pos      (in_start_pos),
    .in_measured_pos   (in_measured_pos),
    .in_target_pos     (in_target_pos),
    .in_clear_integral (in_clear_integral),
    .ctl               (ctl),
    .lim_in            (lim_in),
    .drive             (drive_w),
    .raw_error         (raw_w),
    .on_target         (on_w)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      out_drive_r <= drive_w;
      out_raw_r   <= raw_w;
      out_on_r    <= on_w;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_raw_error = out_raw_r;
  assign out_on_target = out_on_r;

  // a finished item never overwrites a result still waiting
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // sequencer stays busy until its last step completes
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !ctl.fin |=> busy)
    else $error("sequencer dropped an item before its last step");

  // a new result appears only after the last step
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.fin))
    else $error("result valid without a finished item");

endmodule

`default_nettype wire

@@ rtl/core/pidaw_seq.sv @@
// microcode sequencer: step counter, control store and conditional jump
`default_nettype none

module pidaw_seq
  import pidaw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic out_free,
  input  wire logic lim_in,
  output logic      busy,
  output ctl_t      ctl
);

  logic  busy_r, busy_nxt;
  step_t step_r, step_nxt;
  ctl_t  rom_w;
  logic  hold;

  assign rom_w = ucode_rom(step_r);

  // last step waits for a free output slot
  assign hold = rom_w.fin && !out_free;
  assign ctl  = (busy_r && !hold) ? rom_w : CTL_NOP;
  assign busy = busy_r;

  // next step
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = ST_ERR;
      end
    end else if (rom_w.fin) begin
      if (out_free) begin
        busy_nxt = 1'b0;
        step_nxt = ST_ERR;
      end
    end else if (rom_w.chk && lim_in) begin
      step_nxt = rom_w.jmp;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_ERR;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pidaw_dpath.sv @@
// datapath: error wrap, integral, shared multiplier, wide accumulator and clamp
`default_nettype none

module pidaw_dpath
  import pidaw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_load,
  input  wire logic signed [DW-1:0] in_start_pos,
  input  wire logic signed [DW-1:0] in_measured_pos,
  input  wire logic signed [DW-1:0] in_target_pos,
  input  wire logic                 in_clear_integral,
  input  wire ctl_t                 ctl,
  output logic                      lim_in,
  output logic [DW-1:0]             drive,
  output logic [DW-1:0]             raw_error,
  output logic                      on_target
);

  // saturate 34 bits to 32
  function automatic logic [DW-1:0] sat34(input logic [DW+1:0] v);
    if (v[DW+1:DW-1] == 3'b000 || v[DW+1:DW-1] == 3'b111) return v[DW-1:0];
    return v[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // saturate 33 bits to 32
  function automatic logic [DW-1:0] sat33(input logic [DW:0] v);
    if (v[DW] == v[DW-1]) return v[DW-1:0];
    return v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // saturate 49 bits to 48
  function automatic logic [IW-1:0] sat49(input logic [IW:0] v);
    if (v[IW] == v[IW-1]) return v[IW-1:0];
    return v[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
  endfunction

  logic signed [DW:0]   diff_r;
  logic        [DW:0]   dstart_r;
  logic signed [DW-1:0] e_r;
  logic signed [IW-1:0] cand_r;
  logic signed [IW-1:0] integ_r;
  logic signed [DW-1:0] last_err_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [YW-1:0] y_r;
  logic                 on_r;

  logic signed [DW:0]   diff_w;
  logic signed [DW:0]   dstart_w;
  logic signed [DW:0]   span;
  logic signed [DW+1:0] diff_x;
  logic signed [DW+1:0] diff_abs;
  logic signed [DW+2:0] two_abs;
  logic signed [DW+2:0] span_x35;
  logic signed [DW+1:0] span_x34;
  logic signed [DW+1:0] wrapped;
  logic                 diff_pos;
  logic                 wrap_hit;
  logic signed [DW+1:0] err_w;
  logic signed [IW:0]   cand_sum;
  logic                 tol_mode;
  logic signed [MW-1:0] e_x;
  logic signed [MW-1:0] e_abs;
  logic signed [MW-1:0] edif;
  logic signed [MW-1:0] opa_v;
  logic signed [MW-1:0] opb_v;
  logic signed [PW-1:0] prod_w;
  logic signed [AW-1:0] prod_x;
  logic signed [AW-1:0] prod_sh;
  logic signed [AW-1:0] acc_nxt;
  logic signed [PW-1:0] y_x;
  logic signed [AW-1:0] lim_hi;
  logic signed [AW-1:0] lim_lo;

  // input differences taken at acceptance
  assign diff_w   = {in_target_pos[DW-1], in_target_pos}
                  - {in_measured_pos[DW-1], in_measured_pos};
  assign dstart_w = {in_target_pos[DW-1], in_target_pos}
                  - {in_start_pos[DW-1], in_start_pos};

  // span and wrap of the error
  assign span     = {cfg.input_max[DW-1], cfg.input_max}
                  - {cfg.input_min[DW-1], cfg.input_min};
  assign diff_x   = {diff_r[DW], diff_r};
  assign diff_abs = diff_r[DW] ? -diff_x : diff_x;
  assign two_abs  = {diff_abs, 1'b0};
  assign span_x35 = {{2{span[DW]}}, span};
  assign span_x34 = {span[DW], span};
  assign diff_pos = !diff_r[DW] && (diff_r != '0);
  assign wrap_hit = cfg.wrap_mode && (two_abs > span_x35);
  assign wrapped  = diff_pos ? diff_x - span_x34 : diff_x + span_x34;
  assign err_w    = wrap_hit ? wrapped : diff_x;

  // candidate integral
  assign cand_sum = {integ_r[IW-1], integ_r} + {{(IW-DW+1){e_r[DW-1]}}, e_r};

  // on-target test picks its scaling from the sign of the span ends
  assign tol_mode = ($signed(cfg.input_max) > 32'sd0) && ($signed(cfg.input_min) > 32'sd0);

  assign e_x   = {e_r[DW-1], e_r};
  assign e_abs = e_r[DW-1] ? -e_x : e_x;
  assign edif  = e_x - {last_err_r[DW-1], last_err_r};

  // multiplier operand a
  always_comb begin
    unique case (ctl.opa)
      OPA_SPAN:    opa_v = tol_mode ? span : $signed(dstart_r);
      OPA_CAND_LO: opa_v = {1'b0, cand_r[DW-1:0]};
      OPA_CAND_HI: opa_v = {{(MW-IW+DW){cand_r[IW-1]}}, cand_r[IW-1:DW]};
      OPA_ABS_E:   opa_v = e_abs;
      OPA_E:       opa_v = e_x;
      OPA_INT_LO:  opa_v = {1'b0, integ_r[DW-1:0]};
      OPA_INT_HI:  opa_v = {{(MW-IW+DW){integ_r[IW-1]}}, integ_r[IW-1:DW]};
      OPA_EDIF:    opa_v = edif;
      default:     opa_v = '0;
    endcase
  end

  // multiplier operand b
  always_comb begin
    unique case (ctl.opb)
      OPB_TOL: opb_v = TOL_Q16;
      OPB_GI:  opb_v = {cfg.gain_i[DW-1], cfg.gain_i};
      OPB_GP:  opb_v = {cfg.gain_p[DW-1], cfg.gain_p};
      OPB_GD:  opb_v = {cfg.gain_d[DW-1], cfg.gain_d};
      OPB_KX:  opb_v = tol_mode ? KX_SPAN : KX_UNIT;
      default: opb_v = '0;
    endcase
  end

  assign prod_w = opa_v * opb_v;

  // accumulator update
  assign prod_x  = {{(AW-PW){prod_r[PW-1]}}, prod_r};
  assign prod_sh = {prod_x[AW-DW-1:0], {DW{1'b0}}};

  always_comb begin
    case (ctl.acc_op)
      ACC_HOLD:  acc_nxt = acc_r;
      ACC_LOAD:  acc_nxt = prod_x;
      ACC_ADD:   acc_nxt = acc_r + prod_x;
      ACC_ADDSH: acc_nxt = acc_r + prod_sh;
      ACC_CLR:   acc_nxt = (ctl.chk && lim_in) ? acc_r : '0;
      default:   acc_nxt = acc_r;
    endcase
  end

  // drive limits scaled to the accumulator
  assign lim_hi = {{(AW-DW-16){cfg.drive_max[DW-1]}}, cfg.drive_max, 16'h0000};
  assign lim_lo = {{(AW-DW-16){cfg.drive_min[DW-1]}}, cfg.drive_min, 16'h0000};
  assign lim_in = (acc_r < lim_hi) && (acc_r > lim_lo);

  // clamp and truncate
  always_comb begin
    if (acc_r > lim_hi) begin
      drive = cfg.drive_max;
    end else if (acc_r < lim_lo) begin
      drive = cfg.drive_min;
    end else begin
      drive = acc_r[DW+15:16];
    end
  end

  assign raw_error = sat33(diff_r);
  assign y_x       = {{(PW-YW){y_r[YW-1]}}, y_r};
  assign on_target = on_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      diff_r   <= diff_w;
      dstart_r <= dstart_w[DW] ? -dstart_w : dstart_w;
    end
    if (ctl.err_ld) begin
      e_r <= sat34(err_w);
    end
    if (ctl.cand_ld) begin
      cand_r <= sat49(cand_sum);
    end
    if (ctl.mul_en) begin
      prod_r <= prod_w;
    end
    if (ctl.y_ld) begin
      y_r <= prod_r[YW-1:0];
    end
    if (ctl.chk) begin
      on_r <= prod_r < y_x;
    end
    acc_r <= acc_nxt;
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (in_load && in_clear_integral) begin
        integ_r <= '0;
      end else if (ctl.chk && lim_in) begin
        integ_r <= cand_r;
      end
      if (ctl.fin) begin
        last_err_r <= e_r;
      end
    end
  end

endmodule

`default_nettype wire
